>>> hdl/tvm_pkg.sv
package tvm_pkg;

    // Field and word widths fixed by the interface.
    localparam int unsigned ELEM_W  = 32;
    localparam int unsigned REG_W   = 64;
    localparam int unsigned NUM_REGS = 8;
    localparam int unsigned REG_IDX_W = 3;
    localparam int unsigned DIM      = 4;

    // Product and accumulation widths: a 32 x 32 product needs 64 bits,
    // a pair of products 65 and the full four-term sum 66.
    localparam int unsigned PROD_W = 2 * ELEM_W;
    localparam int unsigned PAIR_W = PROD_W + 1;
    localparam int unsigned SUM_W  = PROD_W + 2;

    // Configuration register indexes.
    localparam logic [REG_IDX_W-1:0] REG_ROW0_COLS01 = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_ROW0_COLS23 = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_ROW1_COLS01 = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_ROW1_COLS23 = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_ROW2_COLS01 = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_ROW2_COLS23 = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_ROW3_COLS01 = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_ROW3_COLS23 = 3'd7;

    // One input word: the vector to transform.
    typedef struct packed {
        logic signed [ELEM_W-1:0] in_x;
        logic signed [ELEM_W-1:0] in_y;
        logic signed [ELEM_W-1:0] in_z;
        logic signed [ELEM_W-1:0] in_w;
    } t_in_item;

    // One output word: the transformed vector.
    typedef struct packed {
        logic signed [ELEM_W-1:0] out_x;
        logic signed [ELEM_W-1:0] out_y;
        logic signed [ELEM_W-1:0] out_z;
        logic signed [ELEM_W-1:0] out_w;
    } t_out_item;

endpackage

>>> hdl/transform_vector_by_matrix_core.sv
// 4x4 matrix by 4-vector multiply in signed fixed point with FRAC_BITS fraction
// bits. The matrix sits in eight 64-bit registers, two entries per register with
// the lower column in the low half, and resets to the identity. A vector is
// taken on every clock edge at which start is high; busy never rises, so a new
// word may follow in every cycle. Each result appears on o_out with o_strobe
// high for exactly one cycle once its vector has passed the four pipeline
// stages: the sixteen multipliers, the pair adders, the final adder with the
// rounding constant, and the shift with saturation. The receiver cannot stall
// the output. Rounding is to nearest with ties toward plus infinity, and
// results beyond the signed 32-bit range saturate. Matrix writes take effect
// at once and belong in gaps where no vector is in flight.
module transform_vector_by_matrix_core
    import tvm_pkg::*;
#(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  t_in_item             i_in,
    output logic                 o_strobe,
    output t_out_item            o_out,
    input  logic                 i_cfg_we,
    input  logic [REG_IDX_W-1:0] i_cfg_idx,
    input  logic [REG_W-1:0]     i_cfg_data
);

    localparam logic [REG_W-1:0] ONE_LO  = REG_W'(1) << FRAC_BITS;
    localparam logic [REG_W-1:0] ONE_HI  = REG_W'(1) << (FRAC_BITS + ELEM_W);
    localparam logic [SUM_W-1:0] HALF    = SUM_W'(1) << (FRAC_BITS - 1);

    // Matrix registers.
    logic [REG_W-1:0] r_mat [NUM_REGS];

    // Pipeline valid bits.
    logic r_v1, r_v2, r_v3, r_v4;

    // Data stages.
    logic signed [PROD_W-1:0] r_prod [DIM][DIM];
    logic signed [PROD_W-1:0] n_prod [DIM][DIM];
    logic signed [PAIR_W-1:0] r_pair [DIM][2];
    logic signed [PAIR_W-1:0] n_pair [DIM][2];
    logic signed [SUM_W-1:0]  r_sum  [DIM];
    logic signed [SUM_W-1:0]  n_sum  [DIM];
    t_out_item                r_out;
    t_out_item                n_out;

    logic signed [ELEM_W-1:0] vec [DIM];

    // The pipeline never holds off a new word.
    assign busy = 1'b0;

    // Matrix register writes; reset loads the identity.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mat[REG_ROW0_COLS01] <= ONE_LO;
            r_mat[REG_ROW0_COLS23] <= '0;
            r_mat[REG_ROW1_COLS01] <= ONE_HI;
            r_mat[REG_ROW1_COLS23] <= '0;
            r_mat[REG_ROW2_COLS01] <= '0;
            r_mat[REG_ROW2_COLS23] <= ONE_LO;
            r_mat[REG_ROW3_COLS01] <= '0;
            r_mat[REG_ROW3_COLS23] <= ONE_HI;
        end else if (i_cfg_we) begin
            r_mat[i_cfg_idx] <= i_cfg_data;
        end
    end

    assign vec[0] = i_in.in_x;
    assign vec[1] = i_in.in_y;
    assign vec[2] = i_in.in_z;
    assign vec[3] = i_in.in_w;

    // Stage 1: sixteen signed 32 x 32 products.
    always_comb begin
        logic [REG_W-1:0]         word;
        logic signed [ELEM_W-1:0] coef;
        logic signed [PROD_W-1:0] prod;
        for (int r = 0; r < DIM; r++) begin
            for (int c = 0; c < DIM; c++) begin
                word = r_mat[REG_IDX_W'(2 * r + c / 2)];
                coef = (c % 2 == 1) ? $signed(word[REG_W-1:ELEM_W])
                                    : $signed(word[ELEM_W-1:0]);
                // Assigned at full width, so both factors are sign-extended first.
                prod = coef * vec[c];
                n_prod[r][c] = prod;
            end
        end
    end

    // Stage 2: add the products in pairs.
    always_comb begin
        for (int r = 0; r < DIM; r++) begin
            n_pair[r][0] = PAIR_W'(r_prod[r][0]) + PAIR_W'(r_prod[r][1]);
            n_pair[r][1] = PAIR_W'(r_prod[r][2]) + PAIR_W'(r_prod[r][3]);
        end
    end

    // Stage 3: full-precision row sum with half a result bit added for rounding.
    always_comb begin
        for (int r = 0; r < DIM; r++) begin
            n_sum[r] = SUM_W'(r_pair[r][0]) + SUM_W'(r_pair[r][1]) + $signed(HALF);
        end
    end

    // Stage 4: shift back to the output format and saturate.
    function automatic logic [ELEM_W-1:0] shift_sat(input logic signed [SUM_W-1:0] s);
        logic signed [SUM_W-1:0] sh;
        logic [ELEM_W-1:0]       res;
        sh = s >>> FRAC_BITS;
        if (!sh[SUM_W-1] && (sh[SUM_W-2:ELEM_W-1] != '0)) begin
            res = {1'b0, {(ELEM_W-1){1'b1}}};
        end else if (sh[SUM_W-1] && (sh[SUM_W-2:ELEM_W-1] != '1)) begin
            res = {1'b1, {(ELEM_W-1){1'b0}}};
        end else begin
            res = sh[ELEM_W-1:0];
        end
        return res;
    endfunction

    always_comb begin
        n_out.out_x = $signed(shift_sat(r_sum[0]));
        n_out.out_y = $signed(shift_sat(r_sum[1]));
        n_out.out_z = $signed(shift_sat(r_sum[2]));
        n_out.out_w = $signed(shift_sat(r_sum[3]));
    end

    // Valid bits travel alongside the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= start && !busy;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // Data registers of each stage.
    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
        r_pair <= n_pair;
        r_sum  <= n_sum;
        r_out  <= n_out;
    end

    assign o_strobe = r_v4;
    assign o_out    = r_out;

`ifndef SYNTHESIS
    // Every accepted word gives a result at the end of the pipeline.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##4 o_strobe)
        else $error("accepted word produced no result after four cycles");

    // No result without a matching accepted word.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, 4))
        else $error("result strobe without a matching accepted word");

    // A non-negative row 0 sum never turns into a negative x result.
    a_sign_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && !r_sum[0][SUM_W-1]) |=> !o_out.out_x[ELEM_W-1])
        else $error("positive row 0 sum gave a negative result");

    a_sign_w: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && r_sum[3][SUM_W-1]) |=> o_out.out_w[ELEM_W-1])
        else $error("negative row 3 sum gave a non-negative result");
`endif

endmodule
